// ===== src/particle_euler_integrator_core_defines.svh =====
// assertion helpers for the particle integrator
`ifndef PARTICLE_EULER_INTEGRATOR_CORE_DEFINES_SVH
`define PARTICLE_EULER_INTEGRATOR_CORE_DEFINES_SVH

// same-cycle implication
`define PEI_ASSERT_NOW(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("particle integrator check failed");

// next-cycle implication
`define PEI_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("particle integrator check failed");

`endif

// ===== src/pei_pkg.sv =====
`timescale 1ns / 1ps

package pei_pkg;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic signed [31:0] vel_z;
      logic [15:0]        life_in;
      logic [30:0]        fade_rate;
      logic signed [31:0] angle_in;
      logic signed [31:0] spin_rate;
      logic signed [31:0] gravity_weight;
   } req_payload_type;

   typedef struct packed {
      logic signed [31:0] new_pos_x;
      logic signed [31:0] new_pos_y;
      logic signed [31:0] new_pos_z;
      logic signed [31:0] new_vel_x;
      logic signed [31:0] new_vel_y;
      logic signed [31:0] new_vel_z;
      logic [30:0]        life_out;
      logic signed [31:0] new_angle;
      logic [62:0]        camera_dist_sq;
      logic               alive;
   } rsp_payload_type;

   localparam int CSR_INDEX_W = 3;

   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_STEP = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GRAVITY_X  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_GRAVITY_Y  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_GRAVITY_Z  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_CAMERA_X   = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_CAMERA_Y   = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_CAMERA_Z   = 3'd6;

   localparam logic signed [31:0] GRAVITY_Z_RESET = -32'sd642253;
   localparam logic [30:0]        LIFE_ONE        = 31'd65536;
   localparam logic [30:0]        LIFE_MAX        = 31'h7FFF_FFFF;
   localparam logic [62:0]        DIST_MAX        = 63'h7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [31:0] Q_MAX           = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] Q_MIN           = -32'sh8000_0000;

   // a + floor(p / 2^16), saturated to 32 bit signed
   function automatic logic signed [31:0] add_step_sat(input logic signed [31:0] a,
                                                        input logic signed [63:0] p);
      logic signed [48:0] s;
      s = 49'(a) + 49'($signed(p[63:16]));
      if ((&s[48:31]) || !(|s[48:31])) begin
         return s[31:0];
      end else if (s[48]) begin
         return Q_MIN;
      end else begin
         return Q_MAX;
      end
   endfunction

endpackage

// ===== src/particle_euler_integrator_core.sv =====
`timescale 1ns / 1ps
// Particle Euler step, Q16.16 fixed point. One transaction enters per clock unless req_stall
// is high. Depth is set by the chain of three dependent multiplies (gravity times weight, that
// times the frame step, velocity times the frame step) followed by the squaring and summing
// for the camera distance, each multiply registered. A stall on the result side with a result
// waiting freezes the whole pipeline and is passed straight back as req_stall. csr_ready is
// always high; the user must write registers only while the pipeline is empty (not enforced).

`include "particle_euler_integrator_core_defines.svh"

module particle_euler_integrator_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  pei_pkg::req_payload_type       req_payload,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output pei_pkg::rsp_payload_type       rsp_payload,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [pei_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [31:0]                    csr_wdata
);

   localparam int NSTAGE = 9;

   logic en;
   logic [NSTAGE-1:0] valid_ff;

   logic [30:0]        frame_step_ff;
   logic signed [31:0] grav_ff [3];
   logic signed [31:0] cam_ff [3];
   logic signed [31:0] step_s;

   pei_pkg::req_payload_type req_ff [NSTAGE-1];
   logic [30:0]        life_ff [NSTAGE-2];
   logic signed [31:0] angle_ff [NSTAGE-2];

   logic [61:0]        fade_prod_in, fade_prod_ff;
   logic signed [63:0] spin_prod_in, spin_prod_ff;
   logic signed [31:0] wgt_in [3];
   logic signed [31:0] gvel_in [3];
   logic signed [31:0] gpos_in [3];
   logic signed [63:0] gw_prod_in [3], gw_prod_ff [3];
   logic signed [31:0] gw_ff [3];
   logic signed [63:0] dv_prod_ff [3];
   logic signed [31:0] vel4_ff [3], vel5_ff [3], vel6_ff [3], vel7_ff [3], vel8_ff [3];
   logic signed [63:0] dp_prod_ff [3];
   logic signed [31:0] pos6_ff [3], pos7_ff [3], pos8_ff [3];
   logic signed [32:0] diff_in [3];
   logic [31:0]        mag_in [3], mag_ff [3];
   logic [63:0]        sq_ff [3];

   logic [46:0]        life_sum_in;
   logic [30:0]        life_in;
   logic [65:0]        dist_sum_in;
   logic [62:0]        dist_in;
   logic               alive_in;
   pei_pkg::rsp_payload_type rsp_payload_ff, rsp_payload_in;

   assign en        = !valid_ff[NSTAGE-1] || !rsp_stall;
   assign req_stall = !en;
   assign rsp_valid = valid_ff[NSTAGE-1];
   assign rsp_payload = rsp_payload_ff;
   assign csr_ready = 1'b1;
   assign step_s    = $signed({1'b0, frame_step_ff});

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_step_ff <= '0;
         grav_ff[0]    <= '0;
         grav_ff[1]    <= '0;
         grav_ff[2]    <= pei_pkg::GRAVITY_Z_RESET;
         cam_ff[0]     <= '0;
         cam_ff[1]     <= '0;
         cam_ff[2]     <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            pei_pkg::CSR_FRAME_STEP: frame_step_ff <= csr_wdata[30:0];
            pei_pkg::CSR_GRAVITY_X:  grav_ff[0] <= $signed(csr_wdata);
            pei_pkg::CSR_GRAVITY_Y:  grav_ff[1] <= $signed(csr_wdata);
            pei_pkg::CSR_GRAVITY_Z:  grav_ff[2] <= $signed(csr_wdata);
            pei_pkg::CSR_CAMERA_X:   cam_ff[0] <= $signed(csr_wdata);
            pei_pkg::CSR_CAMERA_Y:   cam_ff[1] <= $signed(csr_wdata);
            pei_pkg::CSR_CAMERA_Z:   cam_ff[2] <= $signed(csr_wdata);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[NSTAGE-2:0], req_valid};
      end
   end

   always_comb begin
      wgt_in[0] = req_payload.gravity_weight;
      wgt_in[1] = req_payload.gravity_weight;
      wgt_in[2] = req_payload.gravity_weight;
      fade_prod_in = req_payload.fade_rate * frame_step_ff;
      spin_prod_in = req_payload.spin_rate * step_s;
      for (int i = 0; i < 3; i++) begin
         gw_prod_in[i] = grav_ff[i] * wgt_in[i];
      end
   end

   always_comb begin
      life_sum_in = 47'(req_ff[0].life_in) + 47'(fade_prod_ff[61:16]);
      if (life_sum_in > 47'(pei_pkg::LIFE_MAX)) begin
         life_in = pei_pkg::LIFE_MAX;
      end else begin
         life_in = life_sum_in[30:0];
      end
   end

   always_comb begin
      gvel_in[0] = req_ff[2].vel_x;
      gvel_in[1] = req_ff[2].vel_y;
      gvel_in[2] = req_ff[2].vel_z;
      gpos_in[0] = req_ff[4].pos_x;
      gpos_in[1] = req_ff[4].pos_y;
      gpos_in[2] = req_ff[4].pos_z;
      for (int i = 0; i < 3; i++) begin
         diff_in[i] = 33'(cam_ff[i]) - 33'(pos6_ff[i]);
         if (diff_in[i][32]) begin
            mag_in[i] = 32'(-diff_in[i]);
         end else begin
            mag_in[i] = diff_in[i][31:0];
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (en) begin
         req_ff[0] <= req_payload;
         for (int k = 1; k < NSTAGE - 1; k++) begin
            req_ff[k] <= req_ff[k-1];
         end
         fade_prod_ff <= fade_prod_in;
         spin_prod_ff <= spin_prod_in;
         life_ff[0]   <= life_in;
         angle_ff[0]  <= pei_pkg::add_step_sat(req_ff[0].angle_in, spin_prod_ff);
         for (int k = 1; k < NSTAGE - 2; k++) begin
            life_ff[k]  <= life_ff[k-1];
            angle_ff[k] <= angle_ff[k-1];
         end
         for (int i = 0; i < 3; i++) begin
            gw_prod_ff[i] <= gw_prod_in[i];
            gw_ff[i]      <= pei_pkg::add_step_sat(32'sd0, gw_prod_ff[i]);
            dv_prod_ff[i] <= gw_ff[i] * step_s;
            vel4_ff[i]    <= pei_pkg::add_step_sat(gvel_in[i], dv_prod_ff[i]);
            dp_prod_ff[i] <= vel4_ff[i] * step_s;
            vel5_ff[i]    <= vel4_ff[i];
            pos6_ff[i]    <= pei_pkg::add_step_sat(gpos_in[i], dp_prod_ff[i]);
            vel6_ff[i]    <= vel5_ff[i];
            mag_ff[i]     <= mag_in[i];
            pos7_ff[i]    <= pos6_ff[i];
            vel7_ff[i]    <= vel6_ff[i];
            sq_ff[i]      <= mag_ff[i] * mag_ff[i];
            pos8_ff[i]    <= pos7_ff[i];
            vel8_ff[i]    <= vel7_ff[i];
         end
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   always_comb begin
      dist_sum_in = 66'(sq_ff[0]) + 66'(sq_ff[1]) + 66'(sq_ff[2]);
      if (|dist_sum_in[65:63]) begin
         dist_in = pei_pkg::DIST_MAX;
      end else begin
         dist_in = dist_sum_in[62:0];
      end
      alive_in = life_ff[NSTAGE-3] < pei_pkg::LIFE_ONE;
      rsp_payload_in.life_out = life_ff[NSTAGE-3];
      rsp_payload_in.alive    = alive_in;
      if (alive_in) begin
         rsp_payload_in.new_pos_x      = pos8_ff[0];
         rsp_payload_in.new_pos_y      = pos8_ff[1];
         rsp_payload_in.new_pos_z      = pos8_ff[2];
         rsp_payload_in.new_vel_x      = vel8_ff[0];
         rsp_payload_in.new_vel_y      = vel8_ff[1];
         rsp_payload_in.new_vel_z      = vel8_ff[2];
         rsp_payload_in.new_angle      = angle_ff[NSTAGE-3];
         rsp_payload_in.camera_dist_sq = dist_in;
      end else begin
         // expired particle keeps its input position, velocity and angle; distance reads zero
         rsp_payload_in.new_pos_x      = req_ff[NSTAGE-2].pos_x;
         rsp_payload_in.new_pos_y      = req_ff[NSTAGE-2].pos_y;
         rsp_payload_in.new_pos_z      = req_ff[NSTAGE-2].pos_z;
         rsp_payload_in.new_vel_x      = req_ff[NSTAGE-2].vel_x;
         rsp_payload_in.new_vel_y      = req_ff[NSTAGE-2].vel_y;
         rsp_payload_in.new_vel_z      = req_ff[NSTAGE-2].vel_z;
         rsp_payload_in.new_angle      = req_ff[NSTAGE-2].angle_in;
         rsp_payload_in.camera_dist_sq = '0;
      end
   end

   `PEI_ASSERT_NEXT(a_accept_enters, clock, reset, req_valid && !req_stall, valid_ff[0])
   `PEI_ASSERT_NEXT(a_freeze_holds, clock, reset, rsp_valid && rsp_stall, $stable(valid_ff))
   `PEI_ASSERT_NOW(a_alive_life, clock, reset, rsp_valid && rsp_payload.alive, rsp_payload.life_out < pei_pkg::LIFE_ONE)

endmodule
